FILE: design/mkslp_pkg.sv
// package: types, constants and key table for the keypad scanner
`timescale 1ns / 1ps

package mkslp_pkg;

	// widths
	localparam int COUNT_W = 15;
	localparam int THR_W   = 14;
	localparam int LOCK_W  = 8;
	localparam int CODE_W  = 8;
	localparam int PAT_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;
	localparam int NUM_KEYS   = 8;

	// default saturation limit of the press counter
	localparam int COUNT_LIMIT_DEF = 10000;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE  = 2'd0,
		CFG_SHORT   = 2'd1,
		CFG_LONG    = 2'd2,
		CFG_LOCKOUT = 2'd3
	} cfg_idx_t;

	// configuration reset values
	localparam logic              ENABLE_RST  = 1'b0;
	localparam logic [THR_W-1:0]  SHORT_RST   = 14'd30;
	localparam logic [THR_W-1:0]  LONG_RST    = 14'd150;
	localparam logic [LOCK_W-1:0] LOCKOUT_RST = 8'd10;
	localparam logic [LOCK_W-1:0] LOCKOUT_MIN = 8'd2;

	// scan phases
	typedef enum logic [1:0] {
		PH_SAMPLE_HI = 2'd0,
		PH_SAMPLE_LO = 2'd1,
		PH_QUALIFY   = 2'd2
	} phase_t;

	// pattern and code constants
	localparam logic [PAT_W-1:0]  PAT_NONE       = 8'hFF;
	localparam logic [CODE_W-1:0] CODE_NONE      = 8'h00;
	localparam logic [CODE_W-1:0] CODE_UNKNOWN   = 8'hFF;
	localparam logic [CODE_W-1:0] CODE_LONG_BASE = 8'h30;

	// one key bit clear for each key, keys 0..7
	localparam logic [PAT_W-1:0] KEY_PAT [NUM_KEYS] = '{
		8'hEF, 8'hDF, 8'hBF, 8'h7F, 8'hFE, 8'hFD, 8'hFB, 8'hF7
	};

	// short code of a held pattern, unknown when not a single key
	function automatic logic [CODE_W-1:0] key_short_code(input logic [PAT_W-1:0] pat);
		logic [CODE_W-1:0] code;
		code = CODE_UNKNOWN;
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (KEY_PAT[i] == pat) begin
				code = CODE_W'(i);
			end
		end
		return code;
	endfunction

endpackage

FILE: design/matrix_keypad_short_long_press.sv
// top level: 2x4 matrix keypad scanner with short and long press codes
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//  in      | in_valid, in_ready, col0..col3            | in
//  out     | out_valid, out_ready, row0_drive,         | out
//          | row1_drive, beeper, key_event, key_code   |
//
// one tick per cycle while in_ready is high: the result is registered, and
// on an enabled tick the scan state updates, as the tick transfers into the
// single output register. a tick is taken while the output register is empty
// or being emptied. cfg_ready is always high. reset gives the register
// defaults, phase set so the first enabled tick samples the upper keys.
`timescale 1ns / 1ps

module matrix_keypad_short_long_press #(
	parameter int COUNT_LIMIT = mkslp_pkg::COUNT_LIMIT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mkslp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mkslp_pkg::CFG_DATA_W-1:0]  cfg_data,
	// tick input
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              col0,
	input  logic                              col1,
	input  logic                              col2,
	input  logic                              col3,
	// result output
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              row0_drive,
	output logic                              row1_drive,
	output logic                              beeper,
	output logic                              key_event,
	output logic [mkslp_pkg::CODE_W-1:0]      key_code
);

	localparam int CW = mkslp_pkg::COUNT_W;
	localparam logic signed [CW-1:0] LIMIT = CW'(COUNT_LIMIT);

	// configuration registers
	logic                              enable_q;
	logic [mkslp_pkg::THR_W-1:0]       short_thr_q;
	logic [mkslp_pkg::THR_W-1:0]       long_thr_q;
	logic [mkslp_pkg::LOCK_W-1:0]      lockout_q;

	// scan state
	mkslp_pkg::phase_t                 phase_q, phase_nx;
	logic [mkslp_pkg::PAT_W-1:0]       pat_q, pat_d;
	logic [mkslp_pkg::PAT_W-1:0]       held_q, held_d;
	logic signed [CW-1:0]              cnt_q, cnt_d;
	logic                              row0_q, row0_d;
	logic                              row1_q, row1_d;
	logic                              beep_q, beep_d;

	// result register
	logic                              out_valid_q;
	logic                              event_q, event_d;
	logic [mkslp_pkg::CODE_W-1:0]      code_q, code_d;

	// helpers
	logic                              in_xfer;
	logic                              step_en;
	logic signed [CW-1:0]              cnt_step;
	logic [mkslp_pkg::LOCK_W-1:0]      lock_len;
	logic signed [CW-1:0]              cnt_lock;
	logic                              pressing;
	logic                              long_hit;
	logic                              short_hit;
	logic [mkslp_pkg::CODE_W-1:0]      short_code;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_xfer   = in_valid && in_ready;
	assign step_en   = in_xfer && enable_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= mkslp_pkg::ENABLE_RST;
			short_thr_q <= mkslp_pkg::SHORT_RST;
			long_thr_q  <= mkslp_pkg::LONG_RST;
			lockout_q   <= mkslp_pkg::LOCKOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (mkslp_pkg::cfg_idx_t'(cfg_index))
				mkslp_pkg::CFG_ENABLE:  enable_q    <= cfg_data[0];
				mkslp_pkg::CFG_SHORT:   short_thr_q <= cfg_data[mkslp_pkg::THR_W-1:0];
				mkslp_pkg::CFG_LONG:    long_thr_q  <= cfg_data[mkslp_pkg::THR_W-1:0];
				mkslp_pkg::CFG_LOCKOUT: lockout_q   <= cfg_data[mkslp_pkg::LOCK_W-1:0];
				default: ;
			endcase
		end
	end

	// next phase
	always_comb begin
		case (phase_q)
			mkslp_pkg::PH_SAMPLE_HI: phase_nx = mkslp_pkg::PH_SAMPLE_LO;
			mkslp_pkg::PH_SAMPLE_LO: phase_nx = mkslp_pkg::PH_QUALIFY;
			default:                 phase_nx = mkslp_pkg::PH_SAMPLE_HI;
		endcase
	end

	// release decay, lockout length and threshold compares
	always_comb begin
		if (cnt_q > 0) begin
			cnt_step = cnt_q - CW'(1);
		end else if (cnt_q < 0) begin
			cnt_step = cnt_q + CW'(1);
		end else begin
			cnt_step = cnt_q;
		end
	end

	assign lock_len   = (lockout_q < mkslp_pkg::LOCKOUT_MIN) ? mkslp_pkg::LOCKOUT_MIN : lockout_q;
	assign cnt_lock   = CW'(0) - CW'(lock_len);
	assign pressing   = (pat_q != mkslp_pkg::PAT_NONE) && !cnt_q[CW-1];
	assign long_hit   = !cnt_step[CW-1] && (cnt_step >= $signed(CW'(long_thr_q)));
	assign short_hit  = !cnt_step[CW-1] && (cnt_step >= $signed(CW'(short_thr_q)));
	assign short_code = mkslp_pkg::key_short_code(held_q);

	// per-phase update of scan state and result
	always_comb begin
		pat_d   = pat_q;
		held_d  = held_q;
		cnt_d   = cnt_q;
		row0_d  = row0_q;
		row1_d  = row1_q;
		beep_d  = beep_q;
		event_d = 1'b0;
		code_d  = mkslp_pkg::CODE_NONE;
		if (enable_q) begin
			case (phase_nx)
				mkslp_pkg::PH_SAMPLE_HI: begin
					pat_d  = {col3, col2, col1, col0, 4'hF};
					row0_d = 1'b0;
					row1_d = 1'b1;
				end
				mkslp_pkg::PH_SAMPLE_LO: begin
					pat_d  = {pat_q[7:4], pat_q[3:0] & {col3, col2, col1, col0}};
					row0_d = 1'b1;
					row1_d = 1'b0;
				end
				default: begin
					if (pressing) begin
						if (pat_q != held_q) begin
							held_d = pat_q;
							cnt_d  = '0;
						end else if (cnt_q < LIMIT) begin
							cnt_d = cnt_q + CW'(1);
						end else begin
							cnt_d = LIMIT;
						end
					end else begin
						cnt_d = cnt_step;
						if (cnt_step == -CW'(1)) begin
							beep_d = 1'b0;
						end
						if (long_hit || short_hit) begin
							event_d = 1'b1;
							if (long_hit) begin
								code_d = (short_code == mkslp_pkg::CODE_UNKNOWN) ?
									mkslp_pkg::CODE_UNKNOWN :
									(mkslp_pkg::CODE_LONG_BASE | short_code);
							end else begin
								code_d = short_code;
							end
							cnt_d  = cnt_lock;
							held_d = mkslp_pkg::PAT_NONE;
							beep_d = 1'b1;
						end
					end
				end
			endcase
		end
	end

	// scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mkslp_pkg::PH_QUALIFY;
			pat_q   <= mkslp_pkg::PAT_NONE;
			held_q  <= mkslp_pkg::PAT_NONE;
			cnt_q   <= '0;
			row0_q  <= 1'b1;
			row1_q  <= 1'b0;
			beep_q  <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_nx;
			pat_q   <= pat_d;
			held_q  <= held_d;
			cnt_q   <= cnt_d;
			row0_q  <= row0_d;
			row1_q  <= row1_d;
			beep_q  <= beep_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			event_q <= event_d;
			code_q  <= code_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign row0_drive = row0_q;
	assign row1_drive = row1_q;
	assign beeper     = beep_q;
	assign key_event  = event_q;
	assign key_code   = code_q;

	// rows are always driven opposite
	a_rows_opposite: assert property (@(posedge clk) disable iff (!arst_n)
		row0_q != row1_q)
		else $error("row drives not complementary");

	// no code without an event
	a_code_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !event_q |-> code_q == mkslp_pkg::CODE_NONE)
		else $error("key code set without key event");

	// an emitted key switches the beeper on
	a_event_beep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && event_q |-> beep_q)
		else $error("key event without beeper");

	// press counter never passes its limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LIMIT)
		else $error("press counter above limit");

	// a disabled tick leaves the phase alone
	a_disabled_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !enable_q |=> $stable(phase_q))
		else $error("phase moved on a disabled tick");

endmodule
